[hw/rtl/lbb_pkg.sv]
// Shared types and constants for the LCD bitmap blit stream unit.
package lbb_pkg;

  localparam int SCREEN_COLS  = 84;
  localparam int SCREEN_ROWS  = 6;

  localparam logic [7:0] WIDTH_MASK   = 8'h3F;
  localparam int         HEIGHT_SHIFT = 6;
  localparam logic [7:0] CMD_SET_COL  = 8'h80;
  localparam logic [7:0] CMD_SET_ROW  = 8'h40;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified strip byte: row commands and/or one data byte.
  typedef struct packed {
    logic       cmds;
    logic       data;
    logic [6:0] col;
    logic [2:0] row;
    logic [7:0] data_val;
  } lbb_job_t;

  typedef enum logic [1:0] {
    BK_HEAD,
    BK_ROW_CMD,
    BK_DATA
  } lbb_back_state_t;

endpackage

[hw/rtl/lbb_front.sv]
// Front end: accepts items, tracks the image position and classifies strip bytes.
module lbb_front
  import lbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [2:0] in_start_row,
  input  logic [6:0] in_start_col,
  input  logic       in_invert_pixels,
  input  logic [7:0] in_image_byte,
  input  logic       q_full,
  output logic       q_push,
  output lbb_job_t   q_job
);

  logic       active_r, active_nxt;
  logic [2:0] rows_left_r, rows_left_nxt;
  logic [6:0] image_width_r, image_width_nxt;
  logic [5:0] strip_offset_r, strip_offset_nxt;
  logic [2:0] current_row_r, current_row_nxt;
  logic [6:0] origin_col_r, origin_col_nxt;
  logic       invert_latch_r, invert_latch_nxt;

  logic       accept;
  logic       row_start;
  logic       col_on_screen;
  logic [6:0] offset_inc;
  logic [3:0] next_row;
  logic [7:0] col_sum;
  logic [7:0] width_field;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign row_start     = (strip_offset_r == 6'd0);
  assign col_sum       = {1'b0, origin_col_r} + {2'b00, strip_offset_r};
  assign col_on_screen = (col_sum < 8'(SCREEN_COLS));
  assign offset_inc    = {1'b0, strip_offset_r} + 7'd1;
  assign next_row      = {1'b0, current_row_r} + 4'd1;
  assign width_field   = in_image_byte & WIDTH_MASK;

  always_comb begin
    q_job.cmds     = row_start;
    q_job.data     = col_on_screen;
    q_job.col      = origin_col_r;
    q_job.row      = current_row_r;
    q_job.data_val = invert_latch_r ? ~in_image_byte : in_image_byte;
  end

  // push only strip bytes that produce at least one result
  assign q_push = accept && in_kind && active_r && (row_start || col_on_screen);

  always_comb begin
    active_nxt       = active_r;
    rows_left_nxt    = rows_left_r;
    image_width_nxt  = image_width_r;
    strip_offset_nxt = strip_offset_r;
    current_row_nxt  = current_row_r;
    origin_col_nxt   = origin_col_r;
    invert_latch_nxt = invert_latch_r;
    if (accept) begin
      if (!in_kind) begin
        rows_left_nxt    = {1'b0, 2'(in_image_byte >> HEIGHT_SHIFT)} + 3'd1;
        image_width_nxt  = {1'b0, width_field[5:0]} + 7'd1;
        strip_offset_nxt = 6'd0;
        current_row_nxt  = in_start_row;
        origin_col_nxt   = in_start_col;
        invert_latch_nxt = in_invert_pixels;
        active_nxt       = ({1'b0, in_start_row} < 4'(SCREEN_ROWS));
      end else if (active_r) begin
        if (offset_inc >= image_width_r) begin
          // end of row: advance to next bank row, drop image past the bottom
          strip_offset_nxt = 6'd0;
          rows_left_nxt    = rows_left_r - 3'd1;
          current_row_nxt  = next_row[2:0];
          if (rows_left_r == 3'd1 || next_row >= 4'(SCREEN_ROWS)) begin
            active_nxt = 1'b0;
          end
        end else begin
          strip_offset_nxt = offset_inc[5:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r       <= 1'b0;
      rows_left_r    <= 3'd0;
      image_width_r  <= 7'd0;
      strip_offset_r <= 6'd0;
      current_row_r  <= 3'd0;
      origin_col_r   <= 7'd0;
      invert_latch_r <= 1'b0;
    end else begin
      active_r       <= active_nxt;
      rows_left_r    <= rows_left_nxt;
      image_width_r  <= image_width_nxt;
      strip_offset_r <= strip_offset_nxt;
      current_row_r  <= current_row_nxt;
      origin_col_r   <= origin_col_nxt;
      invert_latch_r <= invert_latch_nxt;
    end
  end

endmodule

[hw/rtl/lbb_queue.sv]
// Short job queue between the front end and the back end.
module lbb_queue
  import lbb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_push,
  input  lbb_job_t q_job,
  input  logic     q_pop,
  output lbb_job_t q_head,
  output logic     q_full,
  output logic     q_empty
);

  lbb_job_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign q_head  = slot_r[rd_ptr_r];

  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_job;
    end
  end

endmodule

[hw/rtl/lbb_back.sv]
// Back end: expands queued jobs into command and data bytes behind an output register.
module lbb_back
  import lbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lbb_job_t   q_head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_last
);

  lbb_back_state_t state_r, state_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_is_data_r;
  logic       out_last_r;

  logic       load;
  logic [7:0] res_byte;
  logic       res_is_data;
  logic       res_last;

  assign load = !q_empty && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    if (load) begin
      unique case (state_r)
        BK_HEAD:    state_nxt = q_head.cmds ? BK_ROW_CMD : BK_HEAD;
        BK_ROW_CMD: state_nxt = q_head.data ? BK_DATA : BK_HEAD;
        BK_DATA:    state_nxt = BK_HEAD;
        default:    state_nxt = BK_HEAD;
      endcase
    end
  end

  always_comb begin
    res_byte    = q_head.data_val;
    res_is_data = 1'b1;
    res_last    = 1'b1;
    q_pop       = 1'b0;
    unique case (state_r)
      BK_HEAD: begin
        if (q_head.cmds) begin
          res_byte    = CMD_SET_COL | {1'b0, q_head.col};
          res_is_data = 1'b0;
          res_last    = 1'b0;
        end else begin
          q_pop = load;
        end
      end
      BK_ROW_CMD: begin
        res_byte    = CMD_SET_ROW | {5'd0, q_head.row};
        res_is_data = 1'b0;
        res_last    = !q_head.data;
        q_pop       = load && !q_head.data;
      end
      BK_DATA: begin
        q_pop = load;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_HEAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r    <= res_byte;
      out_is_data_r <= res_is_data;
      out_last_r    <= res_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_data = out_is_data_r;
  assign out_last    = out_last_r;

endmodule

[hw/rtl/lcd_bitmap_blit_stream_unit.sv]
// Top level of the LCD bitmap blit stream unit.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------------
//   in      | input     | in_valid / in_ready   | kind, start_row, start_col, invert, byte
//   out     | output    | out_valid / out_ready | out_byte, is_data, last
//
// The front end takes one item per cycle while the job queue has room.
// The back end sends one result byte per cycle while out_ready is high: a strip
// byte yields a data byte when its column is on screen, and one that opens a row
// first yields a column command and a row command.
// Headers and swallowed bytes produce no result.
// Reset is synchronous, active low, and clears image state, queue and output valid.
// A stalled output fills the queue; in_ready drops when the queue is full.
module lcd_bitmap_blit_stream_unit
  import lbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [2:0] in_start_row,
  input  logic [6:0] in_start_col,
  input  logic       in_invert_pixels,
  input  logic [7:0] in_image_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_last
);

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  lbb_job_t q_job;
  lbb_job_t q_head;

  lbb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_start_row     (in_start_row),
    .in_start_col     (in_start_col),
    .in_invert_pixels (in_invert_pixels),
    .in_image_byte    (in_image_byte),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (q_job)
  );

  lbb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  lbb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_head      (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_is_data (out_is_data),
    .out_last    (out_last)
  );

  // a column command never ends an item's results
  a_col_cmd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_data && out_byte[7] |-> !out_last)
    else $error("column command marked last");

  // a row command only addresses an on-screen bank row
  a_row_cmd_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_data && !out_byte[7] |-> ({1'b0, out_byte[2:0]} < 4'(SCREEN_ROWS)))
    else $error("row command addresses an off-screen row");

  // the row command follows its column command in the next cycle
  a_row_after_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_is_data && out_byte[7]
      |=> out_valid && !out_is_data && !out_byte[7])
    else $error("column command not followed by row command");

  // a header never queues a job
  a_header_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_kind |-> !q_push)
    else $error("header produced a job");

endmodule

[tb/sv/tb_lcd_bitmap_blit_stream_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the LCD bitmap blit stream unit.
module tb_lcd_bitmap_blit_stream_unit;
  import lbb_pkg::*;

  localparam logic KIND_HEADER     = 1'b0;
  localparam logic KIND_STRIP      = 1'b1;
  localparam int   CYCLE_LIMIT     = 400000;
  localparam int   HOLD_OFF_CYCLES = 150;
  localparam int   TAIL_CYCLES     = 20;
  localparam int   RANDOM_ITEMS    = 165;
  localparam int   MAX_REPORTS     = 40;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } lcd_byte_t;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_ready;
  logic       in_kind          = 1'b0;
  logic [2:0] in_start_row     = '0;
  logic [6:0] in_start_col     = '0;
  logic       in_invert_pixels = 1'b0;
  logic [7:0] in_image_byte    = '0;
  logic       out_valid;
  logic       out_ready        = 1'b0;
  logic [7:0] out_byte;
  logic       out_is_data;
  logic       out_last;

  // Blitter state as the predictor sees it.
  bit         img_active     = 1'b0;
  logic [2:0] rows_remaining = '0;
  logic [6:0] img_width      = '0;
  logic [5:0] col_offset     = '0;
  logic [2:0] bank_row       = '0;
  logic [6:0] left_col       = '0;
  bit         invert_on      = 1'b0;

  lcd_byte_t  lcd_bytes_due[$];
  int         err_count     = 0;
  int         cycle_count   = 0;
  int         items_counted = 0;
  bit         hold_request  = 1'b0;
  bit         no_idle       = 1'b0;

  lcd_bitmap_blit_stream_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_start_row     (in_start_row),
    .in_start_col     (in_start_col),
    .in_invert_pixels (in_invert_pixels),
    .in_image_byte    (in_image_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_is_data      (out_is_data),
    .out_last         (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (err_count < MAX_REPORTS)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  // Work out the controller bytes one input transfer causes and queue them.
  function automatic int predict_blit(input logic kind, input logic [2:0] srow,
                                      input logic [6:0] scol, input logic inv,
                                      input logic [7:0] pix);
    lcd_byte_t burst [3];
    int        n;
    int        next_row;
    n = 0;
    if (kind == KIND_HEADER) begin
      rows_remaining = 3'(pix >> HEIGHT_SHIFT) + 3'd1;
      img_width      = 7'(pix & WIDTH_MASK) + 7'd1;
      col_offset     = '0;
      bank_row       = srow;
      left_col       = scol;
      invert_on      = inv;
      img_active     = (int'(srow) < SCREEN_ROWS);
      return 0;
    end
    if (!img_active)
      return 0;
    if (col_offset == 6'd0) begin
      burst[n] = '{value: CMD_SET_COL | {1'b0, left_col}, is_data: 1'b0, last: 1'b0};
      n++;
      burst[n] = '{value: CMD_SET_ROW | {5'b0, bank_row}, is_data: 1'b0, last: 1'b0};
      n++;
    end
    if (int'(left_col) + int'(col_offset) < SCREEN_COLS) begin
      burst[n] = '{value: invert_on ? ~pix : pix, is_data: 1'b1, last: 1'b0};
      n++;
    end
    col_offset = col_offset + 6'd1;
    // End of row: the offset reached the width or wrapped past 63.
    if (int'(col_offset) >= int'(img_width) || col_offset == 6'd0) begin
      next_row       = int'(bank_row) + 1;
      col_offset     = '0;
      rows_remaining = rows_remaining - 3'd1;
      if (rows_remaining == 3'd0 || next_row >= SCREEN_ROWS)
        img_active = 1'b0;
      bank_row = 3'(next_row);
    end
    if (n > 0)
      burst[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++)
      lcd_bytes_due.push_back(burst[i]);
    return n;
  endfunction

  function automatic int input_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic int sink_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80)
      return $urandom_range(1, 3);
    if (r < 96)
      return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_item(input logic kind, input logic [2:0] srow, input logic [6:0] scol,
                           input logic inv, input logic [7:0] pix);
    int gap;
    int n;
    gap = input_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_start_row     <= srow;
    in_start_col     <= scol;
    in_invert_pixels <= inv;
    in_image_byte    <= pix;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    n = predict_blit(kind, srow, scol, inv, pix);
    items_counted++;
  endtask

  // Strip bytes carry noise in the header-only fields.
  task automatic send_strip(input logic [7:0] pix);
    send_item(KIND_STRIP, 3'($urandom), 7'($urandom), 1'($urandom), pix);
  endtask

  task automatic drain_lcd_bytes();
    in_valid <= 1'b0;
    do @(posedge clk); while (lcd_bytes_due.size() != 0);
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : lcd_sink
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (sink_stall()) @(posedge clk);
      end
    end
  end

  // Sample at the falling edge, where everything is settled for the next transfer.
  always @(negedge clk) begin : check_lcd_bytes
    lcd_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (lcd_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h is_data %0b last %0b",
                                  out_byte, out_is_data, out_last));
      end else begin
        want = lcd_bytes_due.pop_front();
        if (out_byte !== want.value)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.value));
        if (out_is_data !== want.is_data)
          report_mismatch($sformatf("out_is_data %0b, want %0b", out_is_data, want.is_data));
        if (out_last !== want.last)
          report_mismatch($sformatf("out_last %0b, want %0b", out_last, want.last));
      end
    end
  end

  task automatic test_stray_strips();
    send_strip(8'hFF);
    send_strip(8'h00);
  endtask

  task automatic test_offscreen_start_row();
    send_item(KIND_HEADER, 3'd7, 7'd0, 1'b1, 8'hFF);
    send_strip(8'h81);
    send_strip(8'h7E);
  endtask

  task automatic test_single_pixel();
    send_item(KIND_HEADER, 3'd0, 7'd0, 1'b0, 8'h00);
    send_strip(8'hFF);
    drain_lcd_bytes();
  endtask

  // Last on-screen column, then one past it, inverted.
  task automatic test_right_edge_invert();
    send_item(KIND_HEADER, 3'd5, 7'd83, 1'b1, 8'h01);
    send_strip(8'h00);
    send_strip(8'h5A);
  endtask

  task automatic test_bottom_clip();
    send_item(KIND_HEADER, 3'd5, 7'd10, 1'b0, 8'h40);
    send_strip(8'hC3);
    send_strip(8'h3C);
  endtask

  task automatic test_offscreen_start_col();
    send_item(KIND_HEADER, 3'd0, 7'd127, 1'b0, 8'h40);
    send_strip(8'h11);
    send_strip(8'h22);
    drain_lcd_bytes();
  endtask

  task automatic test_header_replace();
    send_item(KIND_HEADER, 3'd3, 7'd40, 1'b0, 8'h03);
    send_strip(8'hAA);
    send_strip(8'h55);
    // Cut the image short; the new one runs rows 2..5 and ends at the bottom.
    send_item(KIND_HEADER, 3'd2, 7'd0, 1'b1, 8'hC0);
    repeat (5) send_strip(8'($urandom));
    drain_lcd_bytes();
  endtask

  // Widest row at full rate: wraps the offset and clips at the right edge.
  task automatic test_full_rate();
    no_idle = 1'b1;
    send_item(KIND_HEADER, 3'd1, 7'd30, 1'b0, 8'h3F);
    repeat (64) send_strip(8'($urandom));
    drain_lcd_bytes();
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    send_item(KIND_HEADER, 3'd0, 7'd0, 1'b0, 8'h47);
    repeat (16) send_strip(8'($urandom));
    drain_lcd_bytes();
  endtask

  task automatic test_random_images();
    int         base;
    int         r;
    int         strips;
    logic [1:0] hh;
    logic [5:0] ww;
    logic [2:0] srow;
    logic [6:0] scol;
    base = items_counted;
    while (items_counted - base < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 3)) send_strip(8'($urandom));
        continue;
      end
      if ($urandom_range(0, 9) == 0) begin
        ww = 6'($urandom_range(8, 63));
        hh = 2'd0;
      end else begin
        ww = 6'($urandom_range(0, 7));
        hh = 2'($urandom_range(0, 3));
      end
      srow = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
      case ($urandom_range(0, 2))
        0:       scol = 7'($urandom_range(0, 83));
        1:       scol = 7'($urandom_range(60, 100));
        default: scol = 7'($urandom);
      endcase
      strips = (int'(hh) + 1) * (int'(ww) + 1);
      // Truncate some images so the next header lands mid-row.
      if (r < 20)
        strips = $urandom_range(0, strips - 1);
      send_item(KIND_HEADER, srow, scol, 1'($urandom), {hh, ww});
      repeat (strips) send_strip(8'($urandom));
      if ($urandom_range(0, 9) == 0)
        drain_lcd_bytes();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_stray_strips();
    test_offscreen_start_row();
    test_single_pixel();
    test_right_edge_invert();
    test_bottom_clip();
    test_offscreen_start_col();
    test_header_replace();
    test_full_rate();
    test_backpressure();
    test_random_images();
    drain_lcd_bytes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (lcd_bytes_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", lcd_bytes_due.size()));
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
hw/rtl/lbb_pkg.sv
hw/rtl/lbb_front.sv
hw/rtl/lbb_queue.sv
hw/rtl/lbb_back.sv
hw/rtl/lcd_bitmap_blit_stream_unit.sv
tb/sv/tb_lcd_bitmap_blit_stream_unit.sv
